[hdl/sbpm_pkg.sv]
// shared types, constants and helpers of the send buffer pool manager
`timescale 1ns / 1ps
`default_nettype none

package sbpm_pkg;

  localparam int NUM_BUFFERS = 64;
  localparam int NUM_DESTS   = 16;

  localparam int IDX_W   = $clog2(NUM_BUFFERS);
  localparam int LINK_W  = $clog2(NUM_BUFFERS + 1);
  localparam int DEST_W  = $clog2(NUM_DESTS);
  localparam int QCNT_W  = $clog2(NUM_DESTS + 1);
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 7;
  localparam int DCNT_W  = 5;
  localparam int RANK_W  = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 1;
  localparam int WORD_W  = LINK_W + 1;

  typedef logic [LINK_W-1:0] link_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam link_t LINK_NONE = LINK_W'(NUM_BUFFERS);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_CONSUME = 2'd1,
    MODE_RECLAIM = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [REG_W-1:0] {
    REG_DEST_COUNT = 1'b0,
    REG_OWN_RANK   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic  busy;
    link_t link;
  } word_t;

  function automatic logic link_valid(input link_t v);
    return v < LINK_W'(NUM_BUFFERS);
  endfunction

endpackage

`default_nettype wire

[hdl/sbpm_if.sv]
// valid/ready channel interfaces for request and result items
`timescale 1ns / 1ps
`default_nettype none

interface sbpm_in_if
  import sbpm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DEST_W-1:0] dest;
  logic [IDX_W-1:0]  buffer_index;

  modport source (output valid, output mode, output dest, output buffer_index, input ready);
  modport sink   (input valid, input mode, input dest, input buffer_index, output ready);
endinterface

interface sbpm_out_if
  import sbpm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             granted;
  logic [IDX_W-1:0] granted_index;
  logic [CNT_W-1:0] released_count;
  logic             pool_empty;

  modport source (output valid, output granted, output granted_index,
                  output released_count, output pool_empty, input ready);
  modport sink   (input valid, input granted, input granted_index,
                  input released_count, input pool_empty, output ready);
endinterface

`default_nettype wire

[hdl/sbpm_ram.sv]
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sbpm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/send_buffer_pool_manager_core.sv]
// top level of the send buffer pool manager: free list and per-destination queues
// One item is processed at a time. All buffer links and busy marks sit in a single
// ram word per buffer (one read and one write port). An allocate takes the free
// list head and appends it to the destination queue unless the pool is empty; a
// consume clears the busy mark of a buffer; an unused mode does nothing; a reclaim
// pass scans the queues, skipping the own rank, and releases the leading run of
// free buffers of each queue onto the free list, stopping at a busy buffer.
// The result is held in an output register until the sink takes it, and a new
// result waits while a previous one is still held. Link reset values come from
// per-entry valid flops, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module send_buffer_pool_manager_core
  import sbpm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  sbpm_in_if.sink                 in_ch,
  sbpm_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_ALLOC_RD   = 8'b0000_0010,
    S_ALLOC_TAIL = 8'b0000_0100,
    S_CONS_RD    = 8'b0000_1000,
    S_SCAN       = 8'b0001_0000,
    S_WALK       = 8'b0010_0000,
    S_SPLICE     = 8'b0100_0000,
    S_DONE       = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [DCNT_W-1:0] dest_count_r;
  logic [RANK_W-1:0] own_rank_r;
  reg_idx_t          cfg_idx;
  logic              cfg_we;

  link_t head_r [NUM_DESTS];
  link_t head_nxt [NUM_DESTS];
  link_t tail_r [NUM_DESTS];
  link_t tail_nxt [NUM_DESTS];
  link_t pool_top_r, pool_top_nxt;
  logic [NUM_BUFFERS-1:0] ld_valid_r;

  logic [QCNT_W-1:0] q_r, q_nxt;
  link_t             cur_r, cur_nxt;
  idx_t              last_r, last_nxt;
  logic              have_last_r, have_last_nxt;
  link_t             steps_r, steps_nxt;
  logic [CNT_W-1:0]  released_r, released_nxt;
  logic              granted_r, granted_nxt;
  idx_t              gidx_r, gidx_nxt;
  logic [DEST_W-1:0] dest_r, dest_nxt;
  idx_t              bidx_r, bidx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_granted_r;
  idx_t             out_gidx_r;
  logic [CNT_W-1:0] out_released_r;
  logic             out_empty_r;
  logic             out_load;

  logic              mem_we;
  idx_t              mem_waddr;
  word_t             mem_wdata;
  logic              mem_re;
  idx_t              mem_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              rvalid_r;
  idx_t              raddr_r;
  word_t             rd_word;

  logic              in_acc;
  logic [DEST_W-1:0] qi;
  link_t             qh;
  link_t             qt;

  // config port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_DEST_COUNT: prdata = PDATA_W'(dest_count_r);
      REG_OWN_RANK:   prdata = PDATA_W'(own_rank_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_count_r <= DCNT_W'(16);
      own_rank_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DEST_COUNT: dest_count_r <= pwdata[DCNT_W-1:0];
        REG_OWN_RANK:   own_rank_r   <= pwdata[RANK_W-1:0];
        default:        ;
      endcase
    end
  end

  // link / busy ram
  sbpm_ram #(
    .DEPTH (NUM_BUFFERS),
    .WIDTH (WORD_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rvalid_r <= ld_valid_r[mem_raddr];
      raddr_r  <= mem_raddr;
    end
  end

  // unwritten entries read as their reset chain value
  always_comb begin
    if (rvalid_r) begin
      rd_word = word_t'(ram_rdata);
    end else begin
      rd_word.busy = 1'b0;
      rd_word.link = LINK_W'(raddr_r) + LINK_W'(1);
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    pool_top_nxt  = pool_top_r;
    q_nxt         = q_r;
    cur_nxt       = cur_r;
    last_nxt      = last_r;
    have_last_nxt = have_last_r;
    steps_nxt     = steps_r;
    released_nxt  = released_r;
    granted_nxt   = granted_r;
    gidx_nxt      = gidx_r;
    dest_nxt      = dest_r;
    bidx_nxt      = bidx_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    qi            = q_r[DEST_W-1:0];
    qh            = head_r[dest_r];
    qt            = tail_r[dest_r];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dest_nxt     = in_ch.dest;
          bidx_nxt     = in_ch.buffer_index;
          granted_nxt  = 1'b0;
          gidx_nxt     = '0;
          released_nxt = '0;
          q_nxt        = '0;
          unique case (mode_t'(in_ch.mode))
            MODE_ALLOC: begin
              if (link_valid(pool_top_r)) begin
                mem_re    = 1'b1;
                mem_raddr = pool_top_r[IDX_W-1:0];
                state_nxt = S_ALLOC_RD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            MODE_CONSUME: begin
              if (link_valid(LINK_W'(in_ch.buffer_index))) begin
                mem_re    = 1'b1;
                mem_raddr = in_ch.buffer_index;
                state_nxt = S_CONS_RD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            MODE_RECLAIM: state_nxt = S_SCAN;
            default:      state_nxt = S_DONE;
          endcase
        end
      end

      S_ALLOC_RD: begin
        pool_top_nxt   = link_valid(rd_word.link) ? rd_word.link : LINK_NONE;
        mem_we         = 1'b1;
        mem_waddr      = pool_top_r[IDX_W-1:0];
        mem_wdata.busy = 1'b1;
        mem_wdata.link = LINK_NONE;
        granted_nxt    = 1'b1;
        gidx_nxt       = pool_top_r[IDX_W-1:0];
        if (!link_valid(qh) || !link_valid(qt)) begin
          head_nxt[dest_r] = pool_top_r;
          tail_nxt[dest_r] = pool_top_r;
          state_nxt        = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = qt[IDX_W-1:0];
          state_nxt = S_ALLOC_TAIL;
        end
      end

      S_ALLOC_TAIL: begin
        mem_we           = 1'b1;
        mem_waddr        = qt[IDX_W-1:0];
        mem_wdata.busy   = rd_word.busy;
        mem_wdata.link   = LINK_W'(gidx_r);
        tail_nxt[dest_r] = LINK_W'(gidx_r);
        state_nxt        = S_DONE;
      end

      S_CONS_RD: begin
        mem_we         = 1'b1;
        mem_waddr      = bidx_r;
        mem_wdata.busy = 1'b0;
        mem_wdata.link = rd_word.link;
        state_nxt      = S_DONE;
      end

      S_SCAN: begin
        if (q_r < QCNT_W'(NUM_DESTS) && q_r < QCNT_W'(dest_count_r)) begin
          if (qi == own_rank_r) begin
            q_nxt = q_r + QCNT_W'(1);
          end else begin
            cur_nxt       = head_r[qi];
            have_last_nxt = 1'b0;
            steps_nxt     = '0;
            if (link_valid(head_r[qi])) begin
              mem_re    = 1'b1;
              mem_raddr = head_r[qi][IDX_W-1:0];
              state_nxt = S_WALK;
            end else begin
              state_nxt = S_SPLICE;
            end
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_WALK: begin
        if (!rd_word.busy) begin
          last_nxt      = cur_r[IDX_W-1:0];
          have_last_nxt = 1'b1;
          steps_nxt     = steps_r + LINK_W'(1);
          cur_nxt       = rd_word.link;
          if (link_valid(rd_word.link) &&
              (steps_r + LINK_W'(1)) < LINK_W'(NUM_BUFFERS)) begin
            mem_re    = 1'b1;
            mem_raddr = rd_word.link[IDX_W-1:0];
          end else begin
            state_nxt = S_SPLICE;
          end
        end else begin
          state_nxt = S_SPLICE;
        end
      end

      S_SPLICE: begin
        if (have_last_r) begin
          mem_we         = 1'b1;
          mem_waddr      = last_r;
          mem_wdata.busy = 1'b0;
          mem_wdata.link = pool_top_r;
          pool_top_nxt   = head_r[qi];
        end
        head_nxt[qi] = link_valid(cur_r) ? cur_r : LINK_NONE;
        if (!link_valid(cur_r)) begin
          tail_nxt[qi] = LINK_NONE;
        end
        released_nxt = released_r + CNT_W'(steps_r);
        q_nxt        = q_r + QCNT_W'(1);
        state_nxt    = S_SCAN;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pool_top_r  <= '0;
      ld_valid_r  <= '0;
      for (int i = 0; i < NUM_DESTS; i++) begin
        head_r[i] <= LINK_NONE;
        tail_r[i] <= LINK_NONE;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pool_top_r  <= pool_top_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      if (mem_we) begin
        ld_valid_r[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    cur_r       <= cur_nxt;
    last_r      <= last_nxt;
    have_last_r <= have_last_nxt;
    steps_r     <= steps_nxt;
    released_r  <= released_nxt;
    granted_r   <= granted_nxt;
    gidx_r      <= gidx_nxt;
    dest_r      <= dest_nxt;
    bidx_r      <= bidx_nxt;
    if (out_load) begin
      out_granted_r  <= granted_r;
      out_gidx_r     <= gidx_r;
      out_released_r <= released_r;
      out_empty_r    <= !link_valid(pool_top_r);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.granted        = out_granted_r;
  assign out_ch.granted_index  = out_gidx_r;
  assign out_ch.released_count = out_released_r;
  assign out_ch.pool_empty     = out_empty_r;

  a_pool_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    pool_top_r <= LINK_NONE)
    else $error("free list head out of range");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item did not start processing");

  a_grant_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_granted_r |-> out_released_r == '0)
    else $error("allocate result reports released buffers");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> steps_r < LINK_W'(NUM_BUFFERS))
    else $error("queue walk passed its bound");

endmodule

`default_nettype wire

[bench/tb.sv]
// testbench of the send buffer pool manager: random and directed items checked against a predictor
`timescale 1ns / 1ps

module tb;
  import sbpm_pkg::*;

  localparam int STUCK_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    mode_t             mode;
    logic [DEST_W-1:0] dest;
    idx_t              index;
  } req_t;

  typedef struct packed {
    logic             granted;
    idx_t             granted_index;
    logic [CNT_W-1:0] released_count;
    logic             pool_empty;
  } pool_result_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sbpm_in_if  in_ch ();
  sbpm_out_if out_ch ();

  send_buffer_pool_manager_core i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted pool state
  link_t             link_of [NUM_BUFFERS];
  logic              busy_of [NUM_BUFFERS];
  link_t             pool_top;
  link_t             q_head [NUM_DESTS];
  link_t             q_tail [NUM_DESTS];
  logic [DCNT_W-1:0] scan_count;
  logic [RANK_W-1:0] skip_rank;

  req_t         pending_items [$];
  pool_result_t due_results [$];
  req_t         offered;
  pool_result_t seen;
  pool_result_t want;
  int           errors;
  int           stim_count;
  int           hot_dests;
  int           stall_asks;
  int           stall_seen;
  int           hold_left;
  int           stuck_cycles;
  bit           src_idle_on;
  bit           sink_idle_on;

  always #6 clk = ~clk;

  task automatic reset_pool();
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      link_of[i] = link_t'(i + 1);
      busy_of[i] = 1'b0;
    end
    for (int i = 0; i < NUM_DESTS; i++) begin
      q_head[i] = LINK_NONE;
      q_tail[i] = LINK_NONE;
    end
    pool_top   = '0;
    scan_count = DCNT_W'(16);
    skip_rank  = '0;
  endtask

  task automatic pool_step(input req_t r);
    pool_result_t e;
    link_t        h;
    link_t        nx;
    link_t        start;
    link_t        cur;
    link_t        last;
    int           n;
    int           q;
    int           steps;
    int           total;
    e = '0;
    total = 0;
    case (r.mode)
      MODE_ALLOC: begin
        if (pool_top < NUM_BUFFERS) begin
          h = pool_top;
          nx = link_of[h];
          pool_top = (nx < NUM_BUFFERS) ? nx : LINK_NONE;
          link_of[h] = LINK_NONE;
          busy_of[h] = 1'b1;
          if (!(q_head[r.dest] < NUM_BUFFERS) || !(q_tail[r.dest] < NUM_BUFFERS)) begin
            q_head[r.dest] = h;
          end else begin
            link_of[q_tail[r.dest]] = h;
          end
          q_tail[r.dest] = h;
          e.granted = 1'b1;
          e.granted_index = idx_t'(h);
        end
      end
      MODE_CONSUME: begin
        busy_of[r.index] = 1'b0;
      end
      MODE_RECLAIM: begin
        n = (scan_count > NUM_DESTS) ? NUM_DESTS : int'(scan_count);
        for (q = 0; q < n; q++) begin
          if (q != skip_rank) begin
            start = q_head[q];
            cur = start;
            last = LINK_NONE;
            steps = 0;
            while (cur < NUM_BUFFERS && !busy_of[cur] && steps < NUM_BUFFERS) begin
              last = cur;
              cur = link_of[cur];
              steps++;
            end
            // leading free run goes to the front of the free list
            if (last < NUM_BUFFERS) begin
              link_of[last] = pool_top;
              pool_top = start;
            end
            if (!(cur < NUM_BUFFERS)) begin
              cur = LINK_NONE;
            end
            q_head[q] = cur;
            if (!(cur < NUM_BUFFERS)) begin
              q_tail[q] = LINK_NONE;
            end
            total += steps;
          end
        end
        e.released_count = CNT_W'(total);
      end
      default: begin
      end
    endcase
    e.pool_empty = !(pool_top < NUM_BUFFERS);
    due_results.push_back(e);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pool_step(offered);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && !(src_idle_on && $urandom_range(99) < 36)) begin
          offered = pending_items.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.mode         <= offered.mode;
          in_ch.dest         <= offered.dest;
          in_ch.buffer_index <= offered.index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.granted, out_ch.granted_index, out_ch.released_count,
                 out_ch.pool_empty};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected item granted=%0d index=%0d released=%0d empty=%0d",
                   $time, seen.granted, seen.granted_index, seen.released_count,
                   seen.pool_empty);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (seen !== want) begin
            $display({"%0t: mismatch expected granted=%0d index=%0d released=%0d empty=%0d",
                      " actual granted=%0d index=%0d released=%0d empty=%0d"},
                     $time, want.granted, want.granted_index, want.released_count,
                     want.pool_empty, seen.granted, seen.granted_index,
                     seen.released_count, seen.pool_empty);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_seen != stall_asks) begin
        stall_seen = stall_asks;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(sink_idle_on && $urandom_range(99) < 36);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no progress", $time);
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic push_req(input mode_t m, input int d, input int b);
    req_t r;
    r.mode = m;
    r.dest = DEST_W'(d);
    r.index = idx_t'(b);
    pending_items.push_back(r);
    if (m != MODE_UNUSED) begin
      stim_count++;
    end
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [PDATA_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_DEST_COUNT) begin
      scan_count = v[DCNT_W-1:0];
    end else begin
      skip_rank = v[RANK_W-1:0];
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || due_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic add_burst();
    int kind;
    int n;
    int base;
    kind = $urandom_range(99);
    if (kind < 42) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        if (hot_dests > 0 && $urandom_range(99) < 70) begin
          push_req(MODE_ALLOC, $urandom_range(hot_dests - 1), $urandom_range(63));
        end else begin
          push_req(MODE_ALLOC, $urandom_range(15), $urandom_range(63));
        end
      end
    end else if (kind < 72) begin
      n = $urandom_range(1, 12);
      repeat (n) push_req(MODE_CONSUME, $urandom_range(15), $urandom_range(63));
    end else if (kind < 78) begin
      // sweep over a run of buffers, wrapping around the pool
      base = $urandom_range(63);
      n = $urandom_range(8, 64);
      for (int k = 0; k < n; k++) begin
        push_req(MODE_CONSUME, $urandom_range(15), (base + k) % NUM_BUFFERS);
      end
    end else if (kind < 94) begin
      push_req(MODE_RECLAIM, $urandom_range(15), $urandom_range(63));
    end else begin
      push_req(MODE_UNUSED, $urandom_range(15), $urandom_range(63));
    end
  endtask

  initial begin
    int phase_scan [7];
    int phase_rank [7];
    int target;
    phase_scan = '{16, 31, 0, 5, 17, 1, 16};
    phase_rank = '{0, 15, 3, 2, 7, 0, 15};
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ALLOC;
    in_ch.dest = '0;
    in_ch.buffer_index = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    stim_count = 0;
    stall_asks = 0;
    stall_seen = 0;
    hold_left = 0;
    stuck_cycles = 0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    hot_dests = 16;
    reset_pool();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset configuration
    push_req(MODE_UNUSED, 15, 63);
    push_req(MODE_CONSUME, 0, 0);
    push_req(MODE_RECLAIM, 0, 0);
    push_req(MODE_ALLOC, 0, 0);
    push_req(MODE_ALLOC, 15, 63);
    push_req(MODE_ALLOC, 15, 0);
    push_req(MODE_ALLOC, 5, 42);
    push_req(MODE_CONSUME, 0, 1);
    push_req(MODE_RECLAIM, 15, 63);
    push_req(MODE_CONSUME, 0, 2);
    push_req(MODE_CONSUME, 0, 3);
    push_req(MODE_CONSUME, 0, 0);
    push_req(MODE_RECLAIM, 0, 0);
    push_req(MODE_CONSUME, 15, 63);
    push_req(MODE_ALLOC, 15, 21);
    wait_drained();
    // scan none, then scan past the queue count with the top rank skipped
    write_reg(REG_DEST_COUNT, 0);
    write_reg(REG_OWN_RANK, 15);
    push_req(MODE_CONSUME, 0, 4);
    push_req(MODE_RECLAIM, 0, 0);
    wait_drained();
    write_reg(REG_DEST_COUNT, 31);
    push_req(MODE_ALLOC, 15, 0);
    push_req(MODE_ALLOC, 10, 0);
    push_req(MODE_CONSUME, 0, 5);
    push_req(MODE_CONSUME, 0, 6);
    push_req(MODE_RECLAIM, 0, 0);
    push_req(MODE_UNUSED, 0, 0);

    // random phases, one setting each
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      write_reg(REG_DEST_COUNT, phase_scan[p]);
      write_reg(REG_OWN_RANK, phase_rank[p]);
      hot_dests = (phase_scan[p] > NUM_DESTS) ? NUM_DESTS : phase_scan[p];
      src_idle_on = (p != 4);
      sink_idle_on = (p != 4);
      if (p == 1) begin
        stall_asks++;
      end
      target = stim_count + 180;
      while (stim_count < target - 90) add_burst();
      if (p == 2) begin
        wait_drained();
      end
      while (stim_count < target) add_burst();
    end

    wait_drained();
    repeat (150) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sbpm_pkg.sv
hdl/sbpm_if.sv
hdl/sbpm_ram.sv
hdl/send_buffer_pool_manager_core.sv
bench/tb.sv
